// File: rtl/irtx_pkg.sv
package irtx_pkg;

    localparam int DEFAULT_BUFFER_DEPTH = 32;
    localparam logic [15:0] BIT_PERIOD_RESET = 16'd13333;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;

    localparam logic REG_BIT_PERIOD = 1'b0;

    typedef struct packed {
        logic [1:0] mode;
        logic [4:0] index;
        logic [7:0] data;
    } in_item_t;

    typedef struct packed {
        logic led_on;
        logic busy_res;
        logic finished;
    } out_item_t;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_START = 4'b0010,
        PH_DATA  = 4'b0100,
        PH_STOP  = 4'b1000
    } phase_t;

endpackage

// File: rtl/irtx_store.sv
module irtx_store
    import irtx_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH,
    parameter int AW = $clog2(BUFFER_DEPTH)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    entry
);

    logic [7:0] mem [BUFFER_DEPTH];
    logic [7:0] rdata_reg;
    logic [7:0] bypass_data_reg;
    logic       bypass_valid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg       <= mem[raddr];
        bypass_data_reg <= wdata;
    end

    // forward a write that lands on the entry being read in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_valid_reg <= 1'b0;
        end
        else
        begin
            bypass_valid_reg <= we && (waddr == raddr);
        end
    end

    assign entry = bypass_valid_reg ? bypass_data_reg : rdata_reg;

endmodule

// File: rtl/irtx_fsm.sv
module irtx_fsm
    import irtx_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH,
    parameter int AW = $clog2(BUFFER_DEPTH)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [1:0]    mode,
    input  logic [15:0]   bit_period,
    input  logic [7:0]    entry,
    output logic [AW-1:0] position_next,
    output out_item_t     result
);

    localparam logic [AW-1:0] LAST_POS = AW'(BUFFER_DEPTH - 1);

    phase_t        phase_reg, phase_next;
    logic [3:0]    bit_select_reg, bit_select_next;
    logic [AW-1:0] position_reg;
    logic [7:0]    cur_byte_reg, cur_byte_next;
    logic          checksum_reg, checksum_next;
    logic [15:0]   tick_reg, tick_next;
    logic          pending_reg, pending_next;
    logic          led_reg, led_next;
    logic          done;
    logic [16:0]   tick_inc;

    assign tick_inc = {1'b0, tick_reg} + 17'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        bit_select_next = bit_select_reg;
        position_next   = position_reg;
        cur_byte_next   = cur_byte_reg;
        checksum_next   = checksum_reg;
        tick_next       = tick_reg;
        pending_next    = pending_reg;
        led_next        = led_reg;
        done            = 1'b0;
        if (accept)
        begin
            case (mode)
                MODE_TICK:
                begin
                    if (tick_inc >= {1'b0, bit_period})
                    begin
                        tick_next = '0;
                        case (phase_reg)
                            PH_IDLE:
                            begin
                                if (pending_reg)
                                begin
                                    position_next = '0;
                                    checksum_next = 1'b0;
                                    phase_next    = PH_START;
                                end
                            end
                            PH_START:
                            begin
                                bit_select_next = '0;
                                led_next        = 1'b1;
                                cur_byte_next   = entry;
                                phase_next      = PH_DATA;
                            end
                            PH_DATA:
                            begin
                                if (bit_select_reg[3])
                                begin
                                    led_next   = 1'b0;
                                    phase_next = PH_STOP;
                                end
                                else
                                begin
                                    // LED is on for a zero bit
                                    led_next        = ~cur_byte_reg[bit_select_reg[2:0]];
                                    bit_select_next = bit_select_reg + 4'd1;
                                end
                            end
                            default:
                            begin
                                led_next = 1'b0;
                                if (checksum_reg || position_reg == LAST_POS)
                                begin
                                    done          = 1'b1;
                                    pending_next  = 1'b0;
                                    checksum_next = 1'b0;
                                    position_next = '0;
                                    phase_next    = PH_IDLE;
                                end
                                else
                                begin
                                    // the byte after the terminating zero is the checksum
                                    if (cur_byte_reg == 8'd0)
                                    begin
                                        checksum_next = 1'b1;
                                    end
                                    position_next = position_reg + 1'b1;
                                    phase_next    = PH_START;
                                end
                            end
                        endcase
                    end
                    else
                    begin
                        tick_next = tick_inc[15:0];
                    end
                end
                MODE_START:
                begin
                    pending_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_select_reg <= '0;
            position_reg   <= '0;
            cur_byte_reg   <= '0;
            checksum_reg   <= 1'b0;
            tick_reg       <= '0;
            pending_reg    <= 1'b0;
            led_reg        <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bit_select_reg <= bit_select_next;
            position_reg   <= position_next;
            cur_byte_reg   <= cur_byte_next;
            checksum_reg   <= checksum_next;
            tick_reg       <= tick_next;
            pending_reg    <= pending_next;
            led_reg        <= led_next;
        end
    end

    assign result.led_on   = led_next;
    assign result.busy_res = (phase_next != PH_IDLE);
    assign result.finished = done;

endmodule

// File: rtl/ir_message_serial_transmitter.sv
// channel   | direction | handshake             | payload
// in        | input     | in_valid / in_ready   | in_item  (mode, index, data)
// out       | output    | out_valid / out_ready | out_item (led_on, busy_res, finished)
// apb       | input     | psel, penable, pwrite | paddr, pwdata, prdata, pready
//
// One item per cycle while the output is not stalled; each item gives one result item in the cycle after acceptance.
// The message buffer is a one-port-write synchronous RAM read every cycle at the
// byte position; a write to that entry in the same cycle is forwarded.
// Reset (rst_n, async low) clears the bit machine and out_valid and restores the bit period; buffer contents are kept.
// in_ready drops only while a result waits in the output register and out_ready is low.
module ir_message_serial_transmitter
    import irtx_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic [15:0]   bit_period_reg;
    logic          out_valid_reg;
    out_item_t     out_item_reg;
    logic          accept;
    logic          we;
    logic [AW-1:0] position_next;
    logic [7:0]    entry;
    out_item_t     result;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BIT_PERIOD) ? {16'd0, bit_period_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg <= BIT_PERIOD_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_BIT_PERIOD)
        begin
            bit_period_reg <= pwdata[15:0];
        end
    end

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    // drop writes beyond the buffer end
    assign we = accept && (in_item.mode == MODE_WRITE)
                && ({4'd0, in_item.index} < 9'(BUFFER_DEPTH));

    irtx_store #(
        .BUFFER_DEPTH(BUFFER_DEPTH),
        .AW(AW)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (we),
        .waddr (AW'(in_item.index)),
        .wdata (in_item.data),
        .raddr (position_next),
        .entry (entry)
    );

    irtx_fsm #(
        .BUFFER_DEPTH(BUFFER_DEPTH),
        .AW(AW)
    ) u_fsm (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .mode          (in_item.mode),
        .bit_period    (bit_period_reg),
        .entry         (entry),
        .position_next (position_next),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// File: verif/ir_message_serial_transmitter_tb.sv
module ir_message_serial_transmitter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import irtx_pkg::*;

    localparam int          DEPTH       = DEFAULT_BUFFER_DEPTH;
    localparam logic [1:0]  MODE_UNUSED = 2'd3;
    localparam int          MAX_WAIT    = 11;
    localparam int          LONG_HOLD   = 80;
    localparam int          TAIL_CYCLES = 8;
    localparam int          DIR_ROWS    = 16;

    typedef struct packed {
        logic        cfg;
        logic [15:0] period;
        in_item_t    item;
        logic        typed;
        out_item_t   exp;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_item;

    // transmitter model state
    logic [7:0]  msg_mem [DEPTH];
    phase_t      tx_phase;
    logic [3:0]  bit_sel;
    logic [4:0]  byte_pos;
    logic [7:0]  cur_byte;
    logic        csum_next;
    logic        start_pend;
    logic        led_lvl;
    logic [15:0] tick_cnt;
    logic [15:0] period_reg;

    out_item_t   drive_queue [$];
    int          mismatch_count;
    int          items_sent;
    bit          quiet;
    bit          hold_req;

    // index/data on ticks and starts are junk on purpose
    dir_row_t directed_rows [DIR_ROWS] = '{
        '{1'b0, 16'd0, '{MODE_UNUSED, 5'd31, 8'hFF}, 1'b1, '{1'b0, 1'b0, 1'b0}},
        '{1'b0, 16'd0, '{MODE_TICK,   5'd31, 8'hFF}, 1'b1, '{1'b0, 1'b0, 1'b0}},
        '{1'b0, 16'd0, '{MODE_WRITE,  5'd0,  8'h00}, 1'b1, '{1'b0, 1'b0, 1'b0}},
        '{1'b0, 16'd0, '{MODE_WRITE,  5'd31, 8'hFF}, 1'b1, '{1'b0, 1'b0, 1'b0}},
        '{1'b0, 16'd0, '{MODE_WRITE,  5'd1,  8'h5A}, 1'b1, '{1'b0, 1'b0, 1'b0}},
        '{1'b1, 16'd0, '{MODE_TICK,   5'd0,  8'h00}, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{1'b0, 16'd0, '{MODE_START,  5'd0,  8'h00}, 1'b1, '{1'b0, 1'b0, 1'b0}},
        '{1'b0, 16'd0, '{MODE_TICK,   5'd0,  8'h00}, 1'b1, '{1'b0, 1'b1, 1'b0}},
        '{1'b0, 16'd0, '{MODE_START,  5'd31, 8'hFF}, 1'b1, '{1'b0, 1'b1, 1'b0}},
        '{1'b0, 16'd0, '{MODE_TICK,   5'd0,  8'h00}, 1'b1, '{1'b1, 1'b1, 1'b0}},
        '{1'b0, 16'd0, '{MODE_WRITE,  5'd1,  8'h00}, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{1'b0, 16'd0, '{MODE_UNUSED, 5'd0,  8'h00}, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{1'b0, 16'd0, '{MODE_TICK,   5'd7,  8'h3C}, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{1'b0, 16'd0, '{MODE_TICK,   5'd0,  8'h00}, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{1'b0, 16'd0, '{MODE_WRITE,  5'd2,  8'hFF}, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{1'b0, 16'd0, '{MODE_TICK,   5'd0,  8'h00}, 1'b0, '{1'b0, 1'b0, 1'b0}}
    };

    ir_message_serial_transmitter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    function automatic in_item_t item_of(input logic [1:0] mode, input logic [4:0] index,
                                         input logic [7:0] data);
        in_item_t it;
        it.mode  = mode;
        it.index = index;
        it.data  = data;
        return it;
    endfunction

    function automatic in_item_t random_item(input bit allow_start);
        in_item_t it;
        it = item_of(2'($urandom), 5'($urandom), 8'($urandom));
        if (!allow_start && it.mode == MODE_START)
            it.mode = MODE_TICK;
        return it;
    endfunction

    // advance the model by one item and return the LED/busy/finished it drives
    function automatic out_item_t transmit_step(input in_item_t it);
        out_item_t res;
        logic      done;
        done = 1'b0;
        case (it.mode)
            MODE_TICK:
            begin
                if (32'(tick_cnt) + 1 >= 32'(period_reg))
                begin
                    tick_cnt = '0;
                    case (tx_phase)
                        PH_IDLE:
                        begin
                            if (start_pend)
                            begin
                                byte_pos  = '0;
                                csum_next = 1'b0;
                                tx_phase  = PH_START;
                            end
                        end
                        PH_START:
                        begin
                            bit_sel  = '0;
                            led_lvl  = 1'b1;
                            cur_byte = msg_mem[byte_pos];
                            tx_phase = PH_DATA;
                        end
                        PH_DATA:
                        begin
                            if (bit_sel >= 4'd8)
                            begin
                                led_lvl  = 1'b0;
                                tx_phase = PH_STOP;
                            end
                            else
                            begin
                                // LED on for a zero bit
                                led_lvl = ~cur_byte[bit_sel[2:0]];
                                bit_sel++;
                            end
                        end
                        default:
                        begin
                            led_lvl = 1'b0;
                            if (csum_next || int'(byte_pos) + 1 >= DEPTH)
                            begin
                                done       = 1'b1;
                                start_pend = 1'b0;
                                csum_next  = 1'b0;
                                byte_pos   = '0;
                                tx_phase   = PH_IDLE;
                            end
                            else
                            begin
                                if (cur_byte == 8'h00)
                                    csum_next = 1'b1;
                                byte_pos++;
                                tx_phase = PH_START;
                            end
                        end
                    endcase
                end
                else
                    tick_cnt = tick_cnt + 16'd1;
            end
            MODE_WRITE:
                msg_mem[it.index] = it.data;
            MODE_START:
                start_pend = 1'b1;
            default:
                ;
        endcase
        res.led_on   = led_lvl;
        res.busy_res = (tx_phase != PH_IDLE);
        res.finished = done;
        return res;
    endfunction

    task automatic check_drive(input out_item_t got);
        out_item_t want;
        if (drive_queue.size() == 0)
        begin
            $error("output item with nothing expected: %b", got);
            mismatch_count++;
        end
        else
        begin
            want = drive_queue.pop_front();
            if (got.led_on !== want.led_on)
            begin
                $error("led_on: expected %0b, got %0b", want.led_on, got.led_on);
                mismatch_count++;
            end
            if (got.busy_res !== want.busy_res)
            begin
                $error("busy_res: expected %0b, got %0b", want.busy_res, got.busy_res);
                mismatch_count++;
            end
            if (got.finished !== want.finished)
            begin
                $error("finished: expected %0b, got %0b", want.finished, got.finished);
                mismatch_count++;
            end
        end
    endtask

    task automatic offer(input in_item_t it, input bit typed = 1'b0,
                         input out_item_t typed_exp = '0);
        int        gap;
        out_item_t pred;
        gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pred = transmit_step(it);
        drive_queue.push_back(typed ? typed_exp : pred);
        if (it.mode != MODE_UNUSED)
            items_sent++;
    endtask

    task automatic drain_outputs();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (drive_queue.size() != 0);
    endtask

    task automatic write_bit_period(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(REG_BIT_PERIOD) << 2;
        pwdata  <= {16'h0000, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        period_reg  = value;
    endtask

    // tick until the transmitter is idle with no start waiting, mixing in random items when noisy
    task automatic finish_message(input bit noisy);
        while (tx_phase != PH_IDLE || start_pend)
        begin
            if (noisy && $urandom_range(0, 15) == 0)
                offer(random_item(1'b1));
            else
                offer(item_of(MODE_TICK, 5'($urandom), 8'($urandom)));
        end
    endtask

    // body bytes nonzero, then the zero terminator and the checksum where they fit, then a start
    task automatic send_message(input int body_len, input bit noisy);
        for (int i = 0; i < body_len; i++)
            offer(item_of(MODE_WRITE, 5'(i), 8'($urandom_range(1, 255))));
        if (body_len < DEPTH)
            offer(item_of(MODE_WRITE, 5'(body_len), 8'h00));
        if (body_len + 1 < DEPTH)
            offer(item_of(MODE_WRITE, 5'(body_len + 1),
                          ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom)));
        offer(item_of(MODE_START, 5'($urandom), 8'($urandom)));
        finish_message(noisy);
    endtask

    task automatic run_phase(input logic [15:0] period, input int target, input bit allow_start);
        int stop_at;
        drain_outputs();
        write_bit_period(period);
        stop_at = items_sent + target;
        while (items_sent < stop_at)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            if (allow_start && $urandom_range(0, 9) < 7)
                send_message($urandom_range(0, 2), 1'b1);
            else
                repeat ($urandom_range(1, 8)) offer(random_item(allow_start));
        end
        quiet = 1'b0;
        finish_message(1'b0);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        out_ready  = 1'b0;
        stall_left = 0;
        hold_left  = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                check_drive(out_item);
                stall_left = quiet ? 0 : $urandom_range(0, MAX_WAIT);
            end
            else if (out_valid && stall_left > 0)
                stall_left--;
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            else if (hold_left > 0)
                hold_left--;
            out_ready <= (stall_left == 0) && (hold_left == 0);
        end
    end

    initial
    begin
        #2ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        in_item        = '0;
        mismatch_count = 0;
        items_sent     = 0;
        quiet          = 1'b0;
        hold_req       = 1'b0;
        tx_phase       = PH_IDLE;
        bit_sel        = '0;
        byte_pos       = '0;
        cur_byte       = '0;
        csum_next      = 1'b0;
        start_pend     = 1'b0;
        led_lvl        = 1'b0;
        tick_cnt       = '0;
        period_reg     = BIT_PERIOD_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // load every buffer entry so no send reads an unwritten one
        for (int i = 0; i < DEPTH; i++)
            offer(item_of(MODE_WRITE, 5'(i), 8'($urandom)));

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].cfg)
            begin
                drain_outputs();
                write_bit_period(directed_rows[r].period);
            end
            else
                offer(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].exp);
        end
        finish_message(1'b0);

        // back-to-back items against a long output stall
        quiet    = 1'b1;
        hold_req = 1'b1;
        send_message(1, 1'b0);
        quiet    = 1'b0;

        run_phase(16'd1, 60, 1'b1);
        send_message(DEPTH, 1'b1);
        run_phase(16'hFFFF, 40, 1'b0);
        run_phase(16'd2, 60, 1'b1);

        drain_outputs();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
